FILE: rtl/core/rti_pkg.sv
// Shared constants, register indexes and result codes for the ray/triangle intersect block.
`default_nettype none

package rti_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int THRESH_WIDTH    = 48;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 48'd2814749767;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_THRESH
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUT_HIT,
    OUT_PARALLEL,
    OUT_U_RANGE,
    OUT_V_RANGE
  } outcome_t;

endpackage

`default_nettype wire

FILE: rtl/core/rti_front.sv
// Front stage: accepts triangle words and forms edge and origin offset vectors.
`default_nettype none

module rti_front #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire  [9*COORD_WIDTH-1:0]        s_tdata,
  input  wire  signed [COORD_WIDTH-1:0]   ox,
  input  wire  signed [COORD_WIDTH-1:0]   oy,
  input  wire  signed [COORD_WIDTH-1:0]   oz,
  input  wire                             full,
  output logic                            push,
  output logic [9*(COORD_WIDTH+1)-1:0]    edata
);

  localparam int W = COORD_WIDTH;
  localparam int E = COORD_WIDTH + 1;

  logic signed [W-1:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z;
  logic                fv;
  logic [9*E-1:0]      vec;

  assign c0x = s_tdata[0*W +: W];
  assign c0y = s_tdata[1*W +: W];
  assign c0z = s_tdata[2*W +: W];
  assign c1x = s_tdata[3*W +: W];
  assign c1y = s_tdata[4*W +: W];
  assign c1z = s_tdata[5*W +: W];
  assign c2x = s_tdata[6*W +: W];
  assign c2y = s_tdata[7*W +: W];
  assign c2z = s_tdata[8*W +: W];

  // Push the held word into the queue whenever it has room
  assign push     = fv & ~full;
  assign s_tready = ~fv | ~full;

  // Hold one word: edges e1, e2 and offset s = origin - c0
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      vec <= {E'(oz) - E'(c0z), E'(oy) - E'(c0y), E'(ox) - E'(c0x),
              E'(c2z) - E'(c0z), E'(c2y) - E'(c0y), E'(c2x) - E'(c0x),
              E'(c1z) - E'(c0z), E'(c1y) - E'(c0y), E'(c1x) - E'(c0x)};
    end
  end

  assign edata = vec;

endmodule

`default_nettype wire

FILE: rtl/core/rti_queue.sv
// Short register queue between the front stage and the arithmetic pipeline.
`default_nettype none

module rti_queue #(
  parameter int DATA_WIDTH = 8,
  parameter int DEPTH      = 4
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  wire  [DATA_WIDTH-1:0] din,
  output logic                  full,
  input  wire                   pop,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0]      wr_ptr, rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;
  assign dout    = mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rti_div.sv
// Pipelined restoring divider: signed num/den scaled by 2^FRAC_BITS, truncated, saturated.
`default_nettype none

module rti_div #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int NUM_WIDTH   = 100
) (
  input  wire                           clk,
  input  wire                           en,
  input  wire  signed [NUM_WIDTH-1:0]   num,
  input  wire  signed [NUM_WIDTH-1:0]   den,
  output logic signed [COORD_WIDTH-1:0] quo
);

  localparam int W  = COORD_WIDTH;
  localparam int NR = NUM_WIDTH + FRAC_BITS;
  localparam int RW = NR + COORD_WIDTH;

  logic [NR-1:0]        rem [W+1];
  logic [NUM_WIDTH-1:0] dd  [W+1];
  logic [W-1:0]         qq  [W+1];
  logic                 ng  [W+1];
  logic [NUM_WIDTH-1:0] num_mag, den_mag;
  logic [W-1:0]         lim, mag;

  assign num_mag = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
  assign den_mag = den[NUM_WIDTH-1] ? NUM_WIDTH'(-den) : NUM_WIDTH'(den);

  // Load magnitudes, numerator scaled by the fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {num_mag, {FRAC_BITS{1'b0}}};
      dd[0]  <= den_mag;
      qq[0]  <= '0;
      ng[0]  <= num[NUM_WIDTH-1] ^ den[NUM_WIDTH-1];
    end
  end

  // One quotient bit per stage, top bit flags saturation
  for (genvar i = 0; i < W; i++) begin : g_stage
    localparam int K = W - 1 - i;
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = RW'(dd[i]) << K;
    assign ge = (RW'(rem[i]) >= sh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? NR'(RW'(rem[i]) - sh) : rem[i];
        dd[i+1]  <= dd[i];
        qq[i+1]  <= qq[i] | (W'(ge) << K);
        ng[i+1]  <= ng[i];
      end
    end
  end

  assign lim = ng[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - 1'b1);
  assign mag = qq[W][W-1] ? lim : qq[W];

  // Apply sign and register the result
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ng[W] ? $signed(W'(-mag)) : $signed(mag);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rti_back.sv
// Arithmetic pipeline: cross products, determinant, numerators, division and classification.
`default_nettype none

module rti_back #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int OUT_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   qvalid,
  output logic                                  pop,
  input  wire  [9*(COORD_WIDTH+1)-1:0]          qdata,
  input  wire  signed [COORD_WIDTH-1:0]         dx,
  input  wire  signed [COORD_WIDTH-1:0]         dy,
  input  wire  signed [COORD_WIDTH-1:0]         dz,
  input  wire  [rti_pkg::THRESH_WIDTH-1:0]      thr,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [OUT_W-1:0]                      m_tdata,
  output logic [1:0]                            m_tuser
);

  import rti_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int E  = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;
  localparam int NW = 3 * COORD_WIDTH + 4;
  localparam int DL = COORD_WIDTH + 2;
  localparam int NT = 12;
  localparam int LW = 2 * E + 1;
  localparam int HW = 2 * E;

  logic en;
  logic signed [E-1:0] e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
  logic signed [E-1:0] b1_e1x, b1_e1y, b1_e1z, b1_e2x, b1_e2y, b1_e2z;
  logic signed [E-1:0] b1_sx, b1_sy, b1_sz;
  logic signed [E-1:0] b2_e1x, b2_e1y, b2_e1z, b2_e2x, b2_e2y, b2_e2z;
  logic signed [E-1:0] b2_sx, b2_sy, b2_sz;
  logic signed [PW-1:0] pz0, pz1, px0, px1, py0, py1;
  logic signed [PW-1:0] qx0, qx1, qy0, qy1, qz0, qz1;
  logic signed [PW-1:0] px, py, pz, qx, qy, qz;
  logic signed [PW-1:0] ma [NT];
  logic signed [E-1:0]  mb [NT];
  logic signed [LW-1:0] pl [NT];
  logic signed [HW-1:0] ph [NT];
  logic signed [NW-1:0] tm [NT];
  logic signed [NW-1:0] det, nu, nv, nt;
  logic [NW-1:0]        det_mag;
  logic                 par;
  logic                 v1, v2, v3, v4, v5;
  logic                 vv [DL];
  logic                 pv [DL];
  logic signed [W-1:0]  u, v, t, one;
  logic signed [W:0]    uv_sum;
  outcome_t             cls;

  // Stall every stage together while the output word waits
  assign en  = ~m_tvalid | m_tready;
  assign pop = en & qvalid;

  assign e1x = qdata[0*E +: E];
  assign e1y = qdata[1*E +: E];
  assign e1z = qdata[2*E +: E];
  assign e2x = qdata[3*E +: E];
  assign e2y = qdata[4*E +: E];
  assign e2z = qdata[5*E +: E];
  assign sx  = qdata[6*E +: E];
  assign sy  = qdata[7*E +: E];
  assign sz  = qdata[8*E +: E];

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= qvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: partial products of p = dir x e2 and q = s x e1
  always_ff @(posedge clk) begin
    if (en) begin
      pz0 <= PW'(e2y) * PW'(dx);
      pz1 <= PW'(e2x) * PW'(dy);
      px0 <= PW'(e2z) * PW'(dy);
      px1 <= PW'(e2y) * PW'(dz);
      py0 <= PW'(e2x) * PW'(dz);
      py1 <= PW'(e2z) * PW'(dx);
      qx0 <= PW'(sy) * PW'(e1z);
      qx1 <= PW'(sz) * PW'(e1y);
      qy0 <= PW'(sz) * PW'(e1x);
      qy1 <= PW'(sx) * PW'(e1z);
      qz0 <= PW'(sx) * PW'(e1y);
      qz1 <= PW'(sy) * PW'(e1x);
      b1_e1x <= e1x;
      b1_e1y <= e1y;
      b1_e1z <= e1z;
      b1_e2x <= e2x;
      b1_e2y <= e2y;
      b1_e2z <= e2z;
      b1_sx  <= sx;
      b1_sy  <= sy;
      b1_sz  <= sz;
    end
  end

  // Stage 2: finish the cross products
  always_ff @(posedge clk) begin
    if (en) begin
      pz <= pz0 - pz1;
      px <= px0 - px1;
      py <= py0 - py1;
      qx <= qx0 - qx1;
      qy <= qy0 - qy1;
      qz <= qz0 - qz1;
      b2_e1x <= b1_e1x;
      b2_e1y <= b1_e1y;
      b2_e1z <= b1_e1z;
      b2_e2x <= b1_e2x;
      b2_e2y <= b1_e2y;
      b2_e2z <= b1_e2z;
      b2_sx  <= b1_sx;
      b2_sy  <= b1_sy;
      b2_sz  <= b1_sz;
    end
  end

  // Operand pairs of the twelve dot product terms
  assign ma[0]  = pz;  assign mb[0]  = b2_e1z;
  assign ma[1]  = py;  assign mb[1]  = b2_e1y;
  assign ma[2]  = px;  assign mb[2]  = b2_e1x;
  assign ma[3]  = pz;  assign mb[3]  = b2_sz;
  assign ma[4]  = py;  assign mb[4]  = b2_sy;
  assign ma[5]  = px;  assign mb[5]  = b2_sx;
  assign ma[6]  = qz;  assign mb[6]  = E'(dz);
  assign ma[7]  = qy;  assign mb[7]  = E'(dy);
  assign ma[8]  = qx;  assign mb[8]  = E'(dx);
  assign ma[9]  = qz;  assign mb[9]  = b2_e2z;
  assign ma[10] = qy;  assign mb[10] = b2_e2y;
  assign ma[11] = qx;  assign mb[11] = b2_e2x;

  // Stage 3: split each wide operand into halves and multiply each half
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NT; k++) begin
        pl[k] <= LW'($signed({1'b0, ma[k][E-1:0]})) * LW'(mb[k]);
        ph[k] <= HW'($signed(ma[k][PW-1:E])) * HW'(mb[k]);
      end
    end
  end

  // Stage 4: recombine the halves into full terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NT; k++) begin
        tm[k] <= (NW'(ph[k]) <<< E) + NW'(pl[k]);
      end
    end
  end

  // Stage 5: sum into determinant and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      det <= tm[0] + tm[1] + tm[2];
      nu  <= tm[3] + tm[4] + tm[5];
      nv  <= tm[6] + tm[7] + tm[8];
      nt  <= tm[9] + tm[10] + tm[11];
    end
  end

  // Flag a near parallel ray, zero determinant included
  assign det_mag = det[NW-1] ? NW'(-det) : NW'(det);
  assign par     = (det == '0) || (det_mag < NW'(thr));

  rti_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .NUM_WIDTH(NW)) u_div_u (
    .clk(clk), .en(en), .num(nu), .den(det), .quo(u)
  );

  rti_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .NUM_WIDTH(NW)) u_div_v (
    .clk(clk), .en(en), .num(nv), .den(det), .quo(v)
  );

  rti_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .NUM_WIDTH(NW)) u_div_t (
    .clk(clk), .en(en), .num(nt), .den(det), .quo(t)
  );

  // Carry valid and the parallel flag alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) begin
        vv[i] <= 1'b0;
      end
    end else if (en) begin
      vv[0] <= v5;
      for (int i = 1; i < DL; i++) begin
        vv[i] <= vv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv[0] <= par;
      for (int i = 1; i < DL; i++) begin
        pv[i] <= pv[i-1];
      end
    end
  end

  // Classify the result in the order parallel, u range, v range
  assign one    = W'(1) << FRAC_BITS;
  assign uv_sum = (W+1)'(u) + (W+1)'(v);

  always_comb begin
    priority if (pv[DL-1]) begin
      cls = OUT_PARALLEL;
    end else if (u < 0 || u > one) begin
      cls = OUT_U_RANGE;
    end else if (v < 0 || uv_sum > (W+1)'(one)) begin
      cls = OUT_V_RANGE;
    end else begin
      cls = OUT_HIT;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vv[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= cls;
      m_tdata <= (cls == OUT_HIT) ? OUT_W'({t, v, u}) : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ray_triangle_intersect.sv
// Ray/triangle intersection top level: fixed ray in registers, triangle stream in, result stream out.
//
// Usage: write the ray origin, direction and determinant threshold through the
// cfg port while the block is idle, then stream triangles on the s_ group, one
// word per triangle (nine coordinates). Each triangle gives exactly one word on
// the m_ group: m_tuser carries the outcome (hit, near parallel, u out of
// range, v or u+v out of range) and m_tdata carries u, v and t, zero on a miss.
// Throughput is one triangle per cycle while m_tready stays high. A triangle
// passes the front register, the queue write, five product and sum stages (the
// wide dot product terms are split in halves over two of them), the dividers,
// which retire one quotient bit per stage, then the output register. When
// m_tready is low the whole back pipeline holds; the four entry queue and the
// front register keep taking triangles until they fill, then s_tready drops.
// Reset empties all stages and loads the default ray (origin zero, direction
// +z, threshold about 1e-5).
`default_nettype none

module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF,
  localparam int IN_W       = ((9 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // corner0_x, corner0_y, corner0_z, corner1_x .. corner2_z, zero padding
  input  wire  [IN_W-1:0]                     s_tdata,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // bary_u, bary_v, distance_t, zero padding
  output logic [OUT_W-1:0]                    m_tdata,
  // outcome
  output logic [1:0]                          m_tuser,
  input  wire                                 cfg_we,
  input  wire  [rti_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [rti_pkg::THRESH_WIDTH-1:0]    cfg_data
);

  import rti_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int E = COORD_WIDTH + 1;

  logic signed [W-1:0]      ox, oy, oz, dx, dy, dz;
  logic [THRESH_WIDTH-1:0]  thr;
  logic                     push, full, qvalid, pop;
  logic [9*E-1:0]           edata, qdata;

  // Ray registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ox  <= '0;
      oy  <= '0;
      oz  <= '0;
      dx  <= '0;
      dy  <= '0;
      dz  <= W'(64'd1 << FRAC_BITS);
      thr <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: ox  <= cfg_data[W-1:0];
        REG_ORIGIN_Y: oy  <= cfg_data[W-1:0];
        REG_ORIGIN_Z: oz  <= cfg_data[W-1:0];
        REG_DIR_X:    dx  <= cfg_data[W-1:0];
        REG_DIR_Y:    dy  <= cfg_data[W-1:0];
        REG_DIR_Z:    dz  <= cfg_data[W-1:0];
        REG_THRESH:   thr <= cfg_data;
        default:      ;
      endcase
    end
  end

  rti_front #(.COORD_WIDTH(W)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata[9*W-1:0]),
    .ox(ox), .oy(oy), .oz(oz),
    .full(full), .push(push), .edata(edata)
  );

  rti_queue #(.DATA_WIDTH(9*E), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .din(edata), .full(full),
    .pop(pop), .valid(qvalid), .dout(qdata)
  );

  rti_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .qvalid(qvalid), .pop(pop), .qdata(qdata),
    .dx(dx), .dy(dy), .dz(dz), .thr(thr),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // A miss carries zero coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != OUT_HIT) |-> (m_tdata == '0))
    else $error("miss word carries nonzero data");

  // A hit has nonnegative barycentrics
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == OUT_HIT) |-> (!m_tdata[W-1] && !m_tdata[2*W-1]))
    else $error("hit with negative barycentric");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the ray/triangle intersect block.
`timescale 1ns / 100ps

module tb_top;
  import rti_pkg::*;

  localparam int CW       = COORD_WIDTH_DEF;
  localparam int FB       = FRAC_BITS_DEF;
  localparam int IN_W     = ((9 * CW + 7) / 8) * 8;
  localparam int OUT_W    = ((3 * CW + 7) / 8) * 8;
  localparam int WW       = 256;
  localparam int LATENCY  = CW + 9;
  localparam int LIMIT    = 600000;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE  = 1 <<< FB;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [WW-1:0] wide_t;

  typedef struct packed {
    coord_t [8:0] c;          // corner0_x at index 0 .. corner2_z at index 8
  } tri_t;

  typedef struct packed {
    outcome_t oc;
    coord_t   u;
    coord_t   v;
    coord_t   t;
  } hit_t;

  // one row of the directed table; oc is used only when known is set
  typedef struct {
    tri_t     corners;
    bit       known;
    outcome_t oc;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [THRESH_WIDTH-1:0] cfg_data = '0;

  // shadow of the ray registers
  coord_t ray_o [3];
  coord_t ray_d [3];
  logic [THRESH_WIDTH-1:0] ray_thresh;

  hit_t pending_hits[$];
  int   errors = 0;
  int   cycles = 0;
  bit   calm = 1'b0;   // no idling on either side while set
  int   rdy_wait = 0;

  ray_triangle_intersect u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic wide_t wabs(wide_t a);
    return a < 0 ? -a : a;
  endfunction

  // quotient times 2^FB, truncated toward zero, saturated to the coordinate range
  function automatic coord_t fx_ratio(wide_t num, wide_t den);
    logic [WW-1:0] q;
    logic [WW-1:0] lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    q = (wabs(num) << FB) / wabs(den);
    lim = neg ? (WW'(1) << (CW - 1)) : ((WW'(1) << (CW - 1)) - 1);
    if (q > lim) q = lim;
    return neg ? coord_t'(-q) : coord_t'(q);
  endfunction

  function automatic hit_t predict_hit(tri_t tr);
    wide_t c0[3], e1[3], e2[3], d[3], s[3], p[3], q[3];
    wide_t det, num;
    coord_t u, v, t;
    hit_t r;
    r = '{oc: OUT_PARALLEL, u: '0, v: '0, t: '0};
    for (int i = 0; i < 3; i++) begin
      c0[i] = tr.c[i];
      e1[i] = wide_t'(tr.c[3 + i]) - c0[i];
      e2[i] = wide_t'(tr.c[6 + i]) - c0[i];
      d[i]  = ray_d[i];
      s[i]  = wide_t'(ray_o[i]) - c0[i];
    end
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    det = p[0] * e1[0] + p[1] * e1[1] + p[2] * e1[2];
    if (det == 0 || wabs(det) < wide_t'({1'b0, ray_thresh})) return r;
    num = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    u = fx_ratio(num, det);
    if (u < 0 || u > ONE) begin
      r.oc = OUT_U_RANGE;
      return r;
    end
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    num = q[0] * d[0] + q[1] * d[1] + q[2] * d[2];
    v = fx_ratio(num, det);
    if (v < 0 || 64'(u) + 64'(v) > 64'(ONE)) begin
      r.oc = OUT_V_RANGE;
      return r;
    end
    num = q[0] * e2[0] + q[1] * e2[1] + q[2] * e2[2];
    t = fx_ratio(num, det);
    r = '{oc: OUT_HIT, u: u, v: v, t: t};
    return r;
  endfunction

  task automatic cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [THRESH_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    unique case (idx)
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: ray_o[idx] = val[CW-1:0];
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_d[idx - REG_DIR_X] = val[CW-1:0];
      REG_THRESH: ray_thresh = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ray(coord_t o[3], coord_t d[3], logic [THRESH_WIDTH-1:0] th);
    for (int i = 0; i < 3; i++) begin
      cfg_write(CFG_INDEX_WIDTH'(REG_ORIGIN_X + i), THRESH_WIDTH'(o[i]));
    end
    for (int i = 0; i < 3; i++) begin
      cfg_write(CFG_INDEX_WIDTH'(REG_DIR_X + i), THRESH_WIDTH'(d[i]));
    end
    cfg_write(REG_THRESH, th);
  endtask

  // Wait for every result to come back, then let the pipeline settle
  task automatic drain();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Drive one triangle word; the expectation is queued when it is taken
  task automatic send_tri(tri_t tr, bit known, outcome_t oc);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tr;
    do @(posedge clk); while (!s_tready);
    if (known) pending_hits.push_back('{oc: oc, u: '0, v: '0, t: '0});
    else pending_hits.push_back(predict_hit(tr));
  endtask

  function automatic coord_t rnd_full();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t rnd_near(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Mostly small triangles straddling the ray, some wild ones
  function automatic tri_t rnd_tri();
    tri_t tr;
    int mode;
    int span;
    mode = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 8 * ONE : 2 * ONE;
    for (int i = 0; i < 9; i++) begin
      if (mode == 0) tr.c[i] = rnd_full();
      else if (mode == 1) tr.c[i] = ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
      else tr.c[i] = ray_o[i % 3] + rnd_near(span);
    end
    return tr;
  endfunction

  // Accept result words with random stalls, check against the oldest expectation
  always @(posedge clk) begin
    hit_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result word: outcome %0d", m_tuser);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (m_tuser != want.oc) begin
          $error("outcome: expected %0d, got %0d", want.oc, m_tuser);
          errors++;
        end
        if (m_tdata[CW-1:0] != want.u) begin
          $error("bary_u: expected %0h, got %0h", want.u, m_tdata[CW-1:0]);
          errors++;
        end
        if (m_tdata[2*CW-1:CW] != want.v) begin
          $error("bary_v: expected %0h, got %0h", want.v, m_tdata[2*CW-1:CW]);
          errors++;
        end
        if (m_tdata[3*CW-1:2*CW] != want.t) begin
          $error("distance_t: expected %0h, got %0h", want.t, m_tdata[3*CW-1:2*CW]);
          errors++;
        end
      end
      rdy_wait = calm ? 0 : $urandom_range(0, 15);
      m_tready <= (rdy_wait == 0);
    end else if (rdy_wait > 0) begin
      rdy_wait--;
      m_tready <= (rdy_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    tri_t     tr;
    coord_t   o[3], d[3];
    coord_t   zero3[3];
    coord_t   dirz[3];
    dir_row_t rows[$];

    ray_o = '{default: '0};
    ray_d = '{0, 0, ONE};
    ray_thresh = THRESH_RESET;
    zero3 = '{default: '0};
    dirz  = '{0, 0, ONE};

    // Directed table: degenerate triangles and extremes under the reset ray
    tr.c = '{default: '0};
    rows.push_back('{corners: tr, known: 1'b1, oc: OUT_PARALLEL});
    tr.c = '{default: CMAX};
    rows.push_back('{corners: tr, known: 1'b1, oc: OUT_PARALLEL});
    tr.c = '{default: CMIN};
    rows.push_back('{corners: tr, known: 1'b1, oc: OUT_PARALLEL});
    // plain hit: triangle in the plane z = 1 around the origin, listed corner2_z first
    tr.c = '{ONE, ONE, -ONE, ONE, -ONE, ONE, ONE, -ONE, -ONE};
    rows.push_back('{corners: tr, known: 1'b0, oc: OUT_HIT});
    // u out of range, hit behind origin, edge on the ray
    for (int k = 0; k < 9; k++) tr.c[k] = '0;
    tr.c[0] = ONE;      tr.c[1] = ONE;  tr.c[2] = ONE;
    tr.c[3] = 2 * ONE;  tr.c[4] = ONE;  tr.c[5] = ONE;
    tr.c[6] = ONE;      tr.c[7] = 2 * ONE; tr.c[8] = ONE;
    rows.push_back('{corners: tr, known: 1'b0, oc: OUT_HIT});
    tr.c[2] = -3 * ONE; tr.c[5] = -3 * ONE; tr.c[8] = -3 * ONE;
    tr.c[0] = 0; tr.c[1] = 0;
    rows.push_back('{corners: tr, known: 1'b0, oc: OUT_HIT});
    tr.c[0] = -ONE; tr.c[1] = ONE; tr.c[3] = ONE; tr.c[4] = ONE; tr.c[6] = 0; tr.c[7] = 0;
    rows.push_back('{corners: tr, known: 1'b0, oc: OUT_HIT});
    for (int k = 0; k < 9; k++) tr.c[k] = (k % 2 == 0) ? CMAX : CMIN;
    rows.push_back('{corners: tr, known: 1'b0, oc: OUT_HIT});
    for (int k = 0; k < 9; k++) tr.c[k] = (k < 3) ? CMIN : ((k % 3 == 0) ? CMAX : coord_t'(0));
    rows.push_back('{corners: tr, known: 1'b0, oc: OUT_HIT});
    for (int k = 0; k < 9; k++) tr.c[k] = (k == 3 || k == 7) ? CMAX : CMIN;
    rows.push_back('{corners: tr, known: 1'b0, oc: OUT_HIT});
    for (int k = 0; k < 9; k++) tr.c[k] = ((k / 3) == 1) ? ONE : coord_t'(1);
    rows.push_back('{corners: tr, known: 1'b0, oc: OUT_HIT});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r]) send_tri(rows[r].corners, rows[r].known, rows[r].oc);
    s_tvalid <= 1'b0;
    drain();

    // Phases of random triangles under different rays
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_ray(zero3, dirz, THRESH_RESET);
        1: begin
          for (int i = 0; i < 3; i++) begin
            o[i] = rnd_near(4 * ONE);
            d[i] = rnd_near(2 * ONE);
          end
          set_ray(o, d, THRESH_WIDTH'($urandom_range(0, 1000)));
        end
        2: begin
          o = '{CMAX, CMIN, CMAX};
          d = '{CMIN, CMAX, CMIN};
          set_ray(o, d, '0);
        end
        3: set_ray(zero3, dirz, '1);
        4: begin
          for (int i = 0; i < 3; i++) begin
            o[i] = rnd_full();
            d[i] = rnd_full();
          end
          set_ray(o, d, THRESH_WIDTH'({$urandom, $urandom}));
        end
        5: begin
          // an out-of-range index must leave the ray alone
          for (int i = 0; i < 3; i++) begin
            o[i] = rnd_near(ONE);
            d[i] = rnd_near(ONE);
          end
          set_ray(o, d, THRESH_RESET);
          cfg_write(REG_UNUSED, '1);
        end
        6: begin
          o = '{CMIN, CMIN, CMIN};
          d = '{CMAX, CMAX, CMAX};
          set_ray(o, d, 48'd1);
        end
        default: set_ray(zero3, dirz, THRESH_RESET);
      endcase
      calm = (ph == 7);
      for (int n = 0; n < 240; n++) begin
        if (ph != 7 && n % 60 == 30) calm = ~calm;
        send_tri(rnd_tri(), 0, OUT_HIT);
      end
      s_tvalid <= 1'b0;
      calm = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rti_pkg.sv
rtl/core/rti_front.sv
rtl/core/rti_queue.sv
rtl/core/rti_div.sv
rtl/core/rti_back.sv
rtl/core/ray_triangle_intersect.sv
test/tb_top.sv
